>>> rtl/core/triangle_wave_channel_macros.svh
// Assertion macros for the triangle wave channel checker.
// No dependencies; expects clk and arst_n in the scope where a macro is used.
`ifndef TRIANGLE_WAVE_CHANNEL_MACROS_SVH
`define TRIANGLE_WAVE_CHANNEL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TRW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/trw_pkg.sv
// Shared types, constants and lookup functions for the triangle wave channel.
// No dependencies.
`timescale 1ns / 1ps

package trw_pkg;

	localparam int PHASE_FRAC_BITS_DEF = 16;
	localparam int SEQ_BITS = 5;
	localparam int LIN_W = 7;
	localparam int LEN_W = 8;
	localparam int PERIOD_W = 11;
	localparam int STEP_W = 21;
	localparam int LEVEL_W = 4;
	localparam int IDX_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 21;

	localparam logic [PERIOD_W-1:0] MIN_PERIOD = 11'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIN_RELOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONTROL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP = 2'd3;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_QUARTER = 2'd1,
		OP_HALF = 2'd2,
		OP_NOTE = 2'd3
	} trw_op_t;

	typedef struct packed {
		trw_op_t op;
		logic [IDX_W-1:0] length_index;
	} trw_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic length_active;
	} trw_result_t;

	typedef struct packed {
		logic [LIN_W-1:0] linear_reload_value;
		logic control_flag;
		logic [PERIOD_W-1:0] timer_period;
		logic [STEP_W-1:0] phase_step;
	} trw_cfg_t;

	// Length counter load values.
	function automatic logic [LEN_W-1:0] trw_len_lookup(input logic [IDX_W-1:0] idx);
		logic [LEN_W-1:0] v;
		case (idx)
			5'd0: v = 8'd10;
			5'd1: v = 8'd254;
			5'd2: v = 8'd20;
			5'd3: v = 8'd2;
			5'd4: v = 8'd40;
			5'd5: v = 8'd4;
			5'd6: v = 8'd80;
			5'd7: v = 8'd6;
			5'd8: v = 8'd160;
			5'd9: v = 8'd8;
			5'd10: v = 8'd60;
			5'd11: v = 8'd10;
			5'd12: v = 8'd14;
			5'd13: v = 8'd12;
			5'd14: v = 8'd26;
			5'd15: v = 8'd14;
			5'd16: v = 8'd12;
			5'd17: v = 8'd16;
			5'd18: v = 8'd24;
			5'd19: v = 8'd18;
			5'd20: v = 8'd48;
			5'd21: v = 8'd20;
			5'd22: v = 8'd96;
			5'd23: v = 8'd22;
			5'd24: v = 8'd192;
			5'd25: v = 8'd24;
			5'd26: v = 8'd72;
			5'd27: v = 8'd26;
			5'd28: v = 8'd16;
			5'd29: v = 8'd28;
			5'd30: v = 8'd32;
			5'd31: v = 8'd30;
			default: v = '0;
		endcase
		return v;
	endfunction

	// 32-step triangle: falls 15..0 over the first half, rises 0..15 over the second.
	function automatic logic [LEVEL_W-1:0] trw_tri_level(input logic [SEQ_BITS-1:0] pos);
		return pos[SEQ_BITS-1] ? pos[LEVEL_W-1:0] : ~pos[LEVEL_W-1:0];
	endfunction

endpackage

>>> rtl/core/trw_cfg_regs.sv
// Configuration register file for the triangle wave channel.
// Depends on trw_pkg.
`timescale 1ns / 1ps

module trw_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [trw_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [trw_pkg::CFG_DATA_W-1:0]   wr_data,
	output trw_pkg::trw_cfg_t                cfg
);
	import trw_pkg::*;

	trw_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_IDX_LIN_RELOAD: cfg_q.linear_reload_value <= wr_data[LIN_W-1:0];
				CFG_IDX_CONTROL: cfg_q.control_flag <= wr_data[0];
				CFG_IDX_PERIOD: cfg_q.timer_period <= wr_data[PERIOD_W-1:0];
				CFG_IDX_STEP: cfg_q.phase_step <= wr_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/trw_event_unit.sv
// Channel state and the combinational event logic: counters, phase, level.
// Depends on trw_pkg.
`timescale 1ns / 1ps

module trw_event_unit #(
	parameter int PHASE_FRAC_BITS = trw_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  trw_pkg::trw_item_t    item,
	input  trw_pkg::trw_cfg_t     cfg,
	output trw_pkg::trw_result_t  result
);
	import trw_pkg::*;

	localparam int PHASE_W = SEQ_BITS + PHASE_FRAC_BITS;
	localparam int SUM_W = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;

	logic [LIN_W-1:0]   lin_q, lin_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic               reload_q, reload_n;
	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [LEVEL_W-1:0] last_q, last_n;
	logic [SUM_W-1:0]   sum;
	logic               audible;

	always_comb begin
		lin_n = lin_q;
		len_n = len_q;
		reload_n = reload_q;
		case (item.op)
			OP_QUARTER: begin
				if (reload_q)
					lin_n = cfg.linear_reload_value;
				else if (lin_q != '0)
					lin_n = lin_q - LIN_W'(1);
				if (!cfg.control_flag)
					reload_n = 1'b0;
			end
			OP_HALF: begin
				if (!cfg.control_flag && len_q != '0)
					len_n = len_q - LEN_W'(1);
			end
			OP_NOTE: begin
				len_n = trw_len_lookup(item.length_index);
				reload_n = 1'b1;
			end
			default: ;
		endcase

		audible = (len_n != '0) && (lin_n != '0) && (cfg.timer_period >= MIN_PERIOD);

		// Wrap drops the fraction: anything at or past 32.0 restarts at zero.
		sum = SUM_W'(phase_q) + SUM_W'(cfg.phase_step);
		phase_n = phase_q;
		last_n = last_q;
		if (audible && item.op == OP_SAMPLE) begin
			last_n = trw_tri_level(phase_q[PHASE_W-1:PHASE_FRAC_BITS]);
			phase_n = (sum[SUM_W-1:PHASE_W] != '0) ? '0 : sum[PHASE_W-1:0];
		end

		result.level = audible ? last_n : '0;
		result.length_active = (len_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q <= '0;
			len_q <= '0;
			reload_q <= 1'b0;
			phase_q <= '0;
			last_q <= '0;
		end else if (fire) begin
			lin_q <= lin_n;
			len_q <= len_n;
			reload_q <= reload_n;
			phase_q <= phase_n;
			last_q <= last_n;
		end
	end

endmodule

>>> rtl/core/triangle_wave_channel.sv
// Triangle wave channel top level: input register, event unit, result register.
// Depends on trw_pkg, trw_cfg_regs and trw_event_unit.
//
//  channel | handshake                  | beat contents
//  --------+----------------------------+-----------------------------------
//  item    | item_valid / item_stall    | trw_item_t: op, length_index
//  result  | result_valid / result_stall| trw_result_t: level, length_active
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One beat per cycle sustained while result_stall is low; an item beat passes through the item
// register, then the combinational event logic, into the result register, where it is valid
// and can be taken while result_stall is low.
// Reset clears all counters, the phase, the held level and every config register.
// result_stall backs up into item_stall only when both the item register and
// the result register are full; otherwise an item beat is taken while a result waits.
// cfg_ready is always high; write config only while the channel is idle.
`timescale 1ns / 1ps

module triangle_wave_channel #(
	parameter int PHASE_FRAC_BITS = trw_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  trw_pkg::trw_item_t              item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output trw_pkg::trw_result_t            result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [trw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [trw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import trw_pkg::*;

	trw_cfg_t    cfg;
	trw_item_t   item_s1;
	logic        valid_s1;
	trw_result_t result_n;
	trw_result_t result_q;
	logic        result_valid_q;
	logic        out_free;
	logic        fire;
	logic        item_take;

	// Result register can load when empty or being drained this cycle.
	assign out_free = !result_valid_q || !result_stall;
	// Process the held item when the result register can take its beat.
	assign fire = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign item_take = item_valid && !item_stall;

	assign cfg_ready = 1'b1;

	trw_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	trw_event_unit #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_event_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_n)
	);

	// Item register: fill on an accepted beat, drop once processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_take || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (item_take)
			item_s1 <= item;
	end

	// Result register: hold while stalled, advance on each processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= fire || (result_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			result_q <= result_n;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

>>> rtl/core/trw_checker.sv
// Port-level checker for the triangle wave channel, bound to the top level.
// Depends on trw_pkg and triangle_wave_channel_macros.svh.
`timescale 1ns / 1ps
`include "triangle_wave_channel_macros.svh"

module trw_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_stall,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  trw_pkg::trw_result_t            result
);
	import trw_pkg::*;

	// A stalled result beat holds.
	`TRW_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result beat changed while stalled")
	// Input backpressure only comes from a full, stalled result side.
	`TRW_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall, "item_stall without a stalled result")
	// A sounding level needs a running length counter.
	`TRW_ASSERT_NOW(a_level_needs_len, result_valid && result.level != '0, result.length_active, "nonzero level with length counter at zero")

endmodule

bind triangle_wave_channel trw_checker u_trw_checker (.*);

>>> tb/tb_triangle_wave_channel.sv
// Self-checking bench for triangle_wave_channel: directed and random event beats
// against an in-bench model of the counters, the phase and the held level.
// Depends on trw_pkg and the triangle_wave_channel RTL.
`timescale 1ns / 1ps

module tb_triangle_wave_channel;

	import trw_pkg::*;

	localparam int FRAC = PHASE_FRAC_BITS_DEF;
	localparam int PHASE_W = SEQ_BITS + FRAC;
	localparam longint unsigned PHASE_WRAP = 64'd32 << FRAC;
	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_PHASES = 6;
	localparam int EVENTS_PER_PHASE = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	trw_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	trw_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	triangle_wave_channel dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Length counter load values, indexed by the note-start length index.
	logic [LEN_W-1:0] len_load [0:31] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

	// Register shadows, updated when a config beat is taken.
	logic [LIN_W-1:0] reg_reload = '0;
	logic reg_control = 1'b0;
	logic [PERIOD_W-1:0] reg_period = '0;
	logic [STEP_W-1:0] reg_step = '0;

	// Channel state as the block should hold it.
	logic [LIN_W-1:0] lin_cnt = '0;
	logic [LEN_W-1:0] len_cnt = '0;
	logic reload_set = 1'b0;
	logic [PHASE_W-1:0] phase_acc = '0;
	logic [LEVEL_W-1:0] held_level = '0;

	trw_item_t pending_events [$];
	trw_result_t predicted_outputs [$];

	int idle_pct = 28;
	logic hold_arm = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	int cycle_count = 0;
	int n_errors = 0;
	int n_events = 0;
	int n_outputs = 0;
	int n_writes = 0;
	int n_audible = 0;
	int n_wraps = 0;

	initial forever #2 clk = ~clk;

	// Apply one event to the modeled channel and return the level it should emit.
	function automatic trw_result_t advance_channel(input trw_item_t ev);
		trw_result_t r;
		logic [SEQ_BITS-1:0] pos;
		longint unsigned sum;
		logic audible;
		case (ev.op)
			OP_QUARTER: begin
				if (reload_set)
					lin_cnt = reg_reload;
				else if (lin_cnt != 0)
					lin_cnt = lin_cnt - LIN_W'(1);
				if (!reg_control)
					reload_set = 1'b0;
			end
			OP_HALF: begin
				if (!reg_control && len_cnt != 0)
					len_cnt = len_cnt - LEN_W'(1);
			end
			OP_NOTE: begin
				len_cnt = len_load[ev.length_index];
				reload_set = 1'b1;
			end
			default: ;
		endcase
		// Silence is judged after this event's counter updates.
		audible = (len_cnt != 0) && (lin_cnt != 0) && (reg_period >= MIN_PERIOD);
		r.level = '0;
		if (audible) begin
			if (ev.op == OP_SAMPLE) begin
				pos = phase_acc[PHASE_W-1 -: SEQ_BITS];
				held_level = (pos < 16) ? LEVEL_W'(15 - pos) : LEVEL_W'(pos - 16);
				sum = longint'(phase_acc) + longint'(reg_step);
				// Drop the fraction on wrap instead of carrying it.
				if (sum >= PHASE_WRAP) begin
					phase_acc = '0;
					n_wraps++;
				end else begin
					phase_acc = sum[PHASE_W-1:0];
				end
				n_audible++;
			end
			r.level = held_level;
		end
		r.length_active = (len_cnt != 0);
		return r;
	endfunction

	function automatic trw_item_t make_event(input trw_op_t op, input logic [IDX_W-1:0] idx);
		trw_item_t ev;
		ev.op = op;
		ev.length_index = idx;
		return ev;
	endfunction

	// Mostly sample ticks, with enough note starts and frame clocks to keep
	// both counters cycling through loaded, counting and expired.
	function automatic trw_item_t random_event();
		trw_item_t ev;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 58)
			ev.op = OP_SAMPLE;
		else if (roll < 74)
			ev.op = OP_QUARTER;
		else if (roll < 86)
			ev.op = OP_HALF;
		else
			ev.op = OP_NOTE;
		ev.length_index = IDX_W'($urandom);
		return ev;
	endfunction

	task automatic flag_error(input string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	// Write all four registers back to back; call only at a rising edge with
	// the channel idle. Keep cfg_valid high across the writes and drop it after.
	task automatic write_regs(input logic [CFG_DATA_W-1:0] reload_word,
			input logic [CFG_DATA_W-1:0] control_word,
			input logic [CFG_DATA_W-1:0] period_word,
			input logic [CFG_DATA_W-1:0] step_word);
		logic [CFG_IDX_W-1:0] regs [4];
		logic [CFG_DATA_W-1:0] words [4];
		regs[0] = CFG_IDX_LIN_RELOAD;
		regs[1] = CFG_IDX_CONTROL;
		regs[2] = CFG_IDX_PERIOD;
		regs[3] = CFG_IDX_STEP;
		words[0] = reload_word;
		words[1] = control_word;
		words[2] = period_word;
		words[3] = step_word;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= words[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			// Bits above each register's width are ignored by the block.
			case (regs[i])
				CFG_IDX_LIN_RELOAD: reg_reload = words[i][LIN_W-1:0];
				CFG_IDX_CONTROL: reg_control = words[i][0];
				CFG_IDX_PERIOD: reg_period = words[i][PERIOD_W-1:0];
				CFG_IDX_STEP: reg_step = words[i][STEP_W-1:0];
				default: ;
			endcase
			n_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// Hold until every queued event has been sent and every result has come back.
	task automatic wait_drained();
		while (pending_events.size() != 0 || item_valid || predicted_outputs.size() != 0)
			@(posedge clk);
	endtask

	// Sender: present the next queued event, hold it while stalled, and
	// predict its result at the edge where the beat is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				predicted_outputs.push_back(advance_channel(item));
				n_events++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_events.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					item_valid <= 1'b1;
					item <= pending_events.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result beat against the oldest prediction, then
	// pick the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin : receiver
		trw_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				n_outputs++;
				if (predicted_outputs.size() == 0) begin
					flag_error($sformatf("result beat level=%0d length_active=%0d with none pending",
						result.level, result.length_active));
				end else begin
					want = predicted_outputs.pop_front();
					if (result.level !== want.level)
						flag_error($sformatf("level expected %0d, got %0d",
							want.level, result.level));
					if (result.length_active !== want.length_active)
						flag_error($sformatf("length_active expected %0d, got %0d",
							want.length_active, result.length_active));
				end
			end
			result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct);
		end
	end

	// Long receiver hold-off, fired once when armed; the sender keeps offering
	// beats meanwhile so the channel fills and stalls its input.
	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] w_reload;
		logic [CFG_DATA_W-1:0] w_control;
		logic [CFG_DATA_W-1:0] w_period;
		logic [CFG_DATA_W-1:0] w_step;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: period 0 keeps the channel silent whatever the counters do.
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_NOTE, 5'd31));
		pending_events.push_back(make_event(OP_QUARTER, 5'h15));
		pending_events.push_back(make_event(OP_HALF, 5'h0A));
		wait_drained();

		// Shortest audible period, one sequence step per tick: run the length
		// counter from a short load down to zero and watch the channel go quiet.
		write_regs(21'd127, 21'd0, 21'd8, 21'(1) << FRAC);
		pending_events.push_back(make_event(OP_NOTE, 5'd3));
		pending_events.push_back(make_event(OP_QUARTER, 5'd0));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd31));
		pending_events.push_back(make_event(OP_HALF, 5'd0));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_HALF, 5'd0));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_QUARTER, 5'd0));
		pending_events.push_back(make_event(OP_NOTE, 5'd0));
		wait_drained();

		// Control set: length halted and reload kept; period 7 is just too short.
		write_regs(21'd1, 21'd1, 21'd7, 21'h1FFFFF);
		pending_events.push_back(make_event(OP_QUARTER, 5'd0));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_HALF, 5'd0));
		wait_drained();

		// Longest period, largest step: every audible tick from a nonzero phase wraps the phase.
		write_regs(21'd2, 21'd1, 21'd2047, 21'h1FFFFF);
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_QUARTER, 5'd0));
		wait_drained();

		// Reload value 0: a quarter frame with reload pending empties the linear counter.
		write_regs(21'd0, 21'd0, 21'd2047, 21'd0);
		pending_events.push_back(make_event(OP_QUARTER, 5'd0));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		pending_events.push_back(make_event(OP_NOTE, 5'd1));
		pending_events.push_back(make_event(OP_SAMPLE, 5'd0));
		wait_drained();

		// Random settings, with junk above the widths of the reload, control and period registers.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			w_reload = CFG_DATA_W'($urandom);
			case ($urandom_range(0, 3))
				0: w_reload[LIN_W-1:0] = '0;
				1: w_reload[LIN_W-1:0] = 7'd127;
				default: w_reload[LIN_W-1:0] = LIN_W'($urandom_range(1, 126));
			endcase
			w_control = CFG_DATA_W'($urandom);
			w_control[0] = ($urandom_range(0, 99) < 30);
			w_period = CFG_DATA_W'($urandom);
			case ($urandom_range(0, 3))
				0: w_period[PERIOD_W-1:0] = PERIOD_W'($urandom_range(0, 7));
				1: w_period[PERIOD_W-1:0] = MIN_PERIOD;
				2: w_period[PERIOD_W-1:0] = 11'd2047;
				default: w_period[PERIOD_W-1:0] = PERIOD_W'($urandom_range(9, 2046));
			endcase
			case ($urandom_range(0, 4))
				0: w_step = '0;
				1: w_step = 21'h1FFFFF;
				4: w_step = CFG_DATA_W'($urandom);
				default: w_step = CFG_DATA_W'($urandom_range(1, 1 << 18));
			endcase
			write_regs(w_reload, w_control, w_period, w_step);

			// One phase runs with no idling at all; another carries the long hold-off.
			idle_pct <= (p == 2) ? 0 : 28;
			if (p == 4)
				hold_arm <= 1'b1;
			repeat (EVENTS_PER_PHASE)
				pending_events.push_back(random_event());
			wait_drained();
		end

		// Let any stray result beat surface before judging.
		repeat (4) @(posedge clk);
		if (predicted_outputs.size() != 0)
			flag_error($sformatf("%0d results never arrived", predicted_outputs.size()));

		$display("Sent %0d events across %0d register writes: %0d audible ticks, %0d phase wraps",
			n_events, n_writes, n_audible, n_wraps);
		$display("Checked %0d result beats, %0d mismatches", n_outputs, n_errors);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
